// ----- hw/rtl/fba_pkg.sv -----
// fba_pkg: shared types and constants of the frame bitmap allocator
// used by the channel interfaces, the top level and the checker
`default_nettype none

package fba_pkg;

  localparam int MAX_FRAMES_DEF = 4096;
  localparam int WORD_BITS_DEF  = 32;

  localparam int KIND_W   = 2;
  localparam int FRAME_W  = 12;
  localparam int STATUS_W = 3;
  localparam int FCNT_W   = 13;

  localparam logic [FCNT_W-1:0] FCNT_RESET = 13'd4096;

  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_FRAME_COUNT = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC_FIRST = 2'd0,
    KIND_ALLOC_AT    = 2'd1,
    KIND_FREE        = 2'd2,
    KIND_RSVD        = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_ALREADY = 3'd1,
    ST_NO_FREE = 3'd2,
    ST_IN_USE  = 3'd3,
    ST_NOTHING = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_SCAN,
    S_MODIFY
  } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fba_intf.sv -----
// fba_intf: request and result channels of the frame bitmap allocator
// valid/ready handshake with the word payload; depends on fba_pkg
`default_nettype none

interface fba_req_if;
  import fba_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [FRAME_W-1:0] current_frame;
  logic [FRAME_W-1:0] wanted_frame;
  logic               kernel_page;
  logic               rw_page;

  modport source (output valid, kind, current_frame, wanted_frame, kernel_page, rw_page,
                  input ready);
  modport sink (input valid, kind, current_frame, wanted_frame, kernel_page, rw_page,
                output ready);
endinterface

interface fba_rsp_if;
  import fba_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [FRAME_W-1:0]  frame_index;
  logic                present;
  logic                writable;
  logic                user_mode;

  modport source (output valid, status, frame_index, present, writable, user_mode,
                  input ready);
  modport sink (input valid, status, frame_index, present, writable, user_mode,
                output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/frame_bitmap_allocator.sv -----
// frame_bitmap_allocator: first-fit physical frame allocator over a used-bit bitmap
// allocate-at and free read the bitmap word in S_START and update it with the result
// in S_MODIFY; allocate-first scans the words in order from word 0 in S_SCAN;
// already-allocated, nothing-to-free, reserved and out-of-range requests answer from
// S_START; a new word is accepted only in S_IDLE, once the last result is registered,
// in the same cycle where that result can first be taken; the bitmap ram read port
// sets the scan rate; reset clears the map by writing one word per cycle (all NUM_WORDS
// words, 128 by default) before the first word is accepted
`default_nettype none

module frame_bitmap_allocator #(
  parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
  parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  fba_req_if.sink                              req,
  fba_rsp_if.source                            rsp,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fba_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire logic [fba_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [fba_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready
);
  import fba_pkg::*;

  localparam int BW        = $clog2(WORD_BITS);
  localparam int NUM_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  state_t               state, state_next;
  logic [FCNT_W-1:0]    frame_count;
  logic [AW-1:0]        clr_addr, clr_addr_next;
  logic [AW-1:0]        ptr, ptr_next;
  logic [AW-1:0]        chk_addr, chk_addr_next;
  logic                 chk_valid, chk_valid_next;

  kind_t                kind_q;
  logic [FRAME_W-1:0]   cur_q;
  logic [FRAME_W-1:0]   want_q;
  logic                 kern_q;
  logic                 wr_q;

  logic                 out_valid, out_valid_next;
  status_t              out_status, out_status_next;
  logic [FRAME_W-1:0]   out_frame, out_frame_next;
  logic                 out_present, out_present_next;
  logic                 out_writable, out_writable_next;
  logic                 out_user, out_user_next;

  logic                 mem_wr_en;
  logic [AW-1:0]        mem_wr_addr;
  logic [WORD_BITS-1:0] mem_wr_data;
  logic                 mem_rd_en;
  logic [AW-1:0]        mem_rd_addr;
  logic [WORD_BITS-1:0] mem_rd_data;

  logic [FCNT_W-1:0]    lim, lim_m1;
  logic [AW-1:0]        last_word;
  logic [BW-1:0]        lim_lo;
  logic [AW-1:0]        cur_word, want_word;
  logic [BW-1:0]        cur_bit, want_bit;
  logic [WORD_BITS-1:0] vmask, free_bits, lowest;
  logic [BW-1:0]        low_idx;
  logic                 any_free;
  logic                 can_emit;
  logic                 accept;

  fba_bitmap_ram #(
    .WORD_BITS (WORD_BITS),
    .NUM_WORDS (NUM_WORDS),
    .AW        (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_FRAME_COUNT) ?
                  APB_DATA_W'(frame_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FCNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[CFG_ADDR_W-1:2] == REG_FRAME_COUNT) begin
      frame_count <= pwdata[FCNT_W-1:0];
    end
  end

  // managed range and bit positions
  always_comb begin
    if (32'(frame_count) > 32'(MAX_FRAMES)) begin
      lim = FCNT_W'(MAX_FRAMES);
    end else begin
      lim = frame_count;
    end
    lim_m1    = lim - FCNT_W'(1);
    last_word = AW'(32'(lim_m1) >> BW);
    lim_lo    = lim_m1[BW-1:0];
    cur_word  = AW'(32'(cur_q) >> BW);
    want_word = AW'(32'(want_q) >> BW);
    cur_bit   = cur_q[BW-1:0];
    want_bit  = want_q[BW-1:0];
  end

  // lowest free bit of the word under check
  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      vmask[b] = (chk_addr != last_word) || (BW'(b) <= lim_lo);
    end
    free_bits = ~mem_rd_data & vmask;
    any_free  = |free_bits;
    lowest    = free_bits & (~free_bits + WORD_BITS'(1));
    low_idx   = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (lowest[b]) begin
        low_idx = low_idx | BW'(b);
      end
    end
  end

  assign can_emit  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  always_comb begin
    state_next        = state;
    clr_addr_next     = clr_addr;
    ptr_next          = ptr;
    chk_addr_next     = chk_addr;
    chk_valid_next    = chk_valid;
    out_valid_next    = out_valid && !rsp.ready;
    out_status_next   = out_status;
    out_frame_next    = out_frame;
    out_present_next  = out_present;
    out_writable_next = out_writable;
    out_user_next     = out_user;
    mem_wr_en         = 1'b0;
    mem_wr_addr       = chk_addr;
    mem_wr_data       = mem_rd_data;
    mem_rd_en         = 1'b0;
    mem_rd_addr       = ptr;

    case (state)
      S_CLEAR: begin
        mem_wr_en     = 1'b1;
        mem_wr_addr   = clr_addr;
        mem_wr_data   = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(NUM_WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_START;
        end
      end
      S_START: begin
        if ((kind_q == KIND_ALLOC_FIRST || kind_q == KIND_ALLOC_AT) && cur_q != '0) begin
          if (can_emit) begin
            out_valid_next    = 1'b1;
            out_status_next   = ST_ALREADY;
            out_frame_next    = cur_q;
            out_present_next  = 1'b0;
            out_writable_next = 1'b0;
            out_user_next     = 1'b0;
            state_next        = S_IDLE;
          end
        end else begin
          case (kind_q)
            KIND_ALLOC_FIRST: begin
              if (lim == '0) begin
                if (can_emit) begin
                  out_valid_next    = 1'b1;
                  out_status_next   = ST_NO_FREE;
                  out_frame_next    = '0;
                  out_present_next  = 1'b0;
                  out_writable_next = 1'b0;
                  out_user_next     = 1'b0;
                  state_next        = S_IDLE;
                end
              end else begin
                ptr_next       = '0;
                chk_valid_next = 1'b0;
                state_next     = S_SCAN;
              end
            end
            KIND_ALLOC_AT: begin
              if (FCNT_W'(want_q) >= lim) begin
                if (can_emit) begin
                  out_valid_next    = 1'b1;
                  out_status_next   = ST_NO_FREE;
                  out_frame_next    = '0;
                  out_present_next  = 1'b0;
                  out_writable_next = 1'b0;
                  out_user_next     = 1'b0;
                  state_next        = S_IDLE;
                end
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = want_word;
                state_next  = S_MODIFY;
              end
            end
            KIND_FREE: begin
              if (cur_q == '0 || 32'(cur_q) >= 32'(MAX_FRAMES)) begin
                if (can_emit) begin
                  out_valid_next    = 1'b1;
                  out_status_next   = (cur_q == '0) ? ST_NOTHING : ST_OK;
                  out_frame_next    = '0;
                  out_present_next  = 1'b0;
                  out_writable_next = 1'b0;
                  out_user_next     = 1'b0;
                  state_next        = S_IDLE;
                end
              end else begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = cur_word;
                state_next  = S_MODIFY;
              end
            end
            default: begin
              if (can_emit) begin
                out_valid_next    = 1'b1;
                out_status_next   = ST_OK;
                out_frame_next    = cur_q;
                out_present_next  = 1'b0;
                out_writable_next = 1'b0;
                out_user_next     = 1'b0;
                state_next        = S_IDLE;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (chk_valid && any_free) begin
          if (can_emit) begin
            mem_wr_en         = 1'b1;
            mem_wr_addr       = chk_addr;
            mem_wr_data       = mem_rd_data | lowest;
            out_valid_next    = 1'b1;
            out_status_next   = ST_OK;
            out_frame_next    = FRAME_W'((32'(chk_addr) << BW) | 32'(low_idx));
            out_present_next  = 1'b1;
            out_writable_next = wr_q;
            out_user_next     = !kern_q;
            state_next        = S_IDLE;
          end
        end else if (chk_valid && chk_addr == last_word) begin
          if (can_emit) begin
            out_valid_next    = 1'b1;
            out_status_next   = ST_NO_FREE;
            out_frame_next    = '0;
            out_present_next  = 1'b0;
            out_writable_next = 1'b0;
            out_user_next     = 1'b0;
            state_next        = S_IDLE;
          end
        end else begin
          mem_rd_en      = 1'b1;
          mem_rd_addr    = ptr;
          chk_addr_next  = ptr;
          chk_valid_next = 1'b1;
          ptr_next       = ptr + AW'(1);
        end
      end
      S_MODIFY: begin
        if (can_emit) begin
          out_valid_next    = 1'b1;
          out_status_next   = ST_OK;
          out_frame_next    = '0;
          out_present_next  = 1'b0;
          out_writable_next = 1'b0;
          out_user_next     = 1'b0;
          state_next        = S_IDLE;
          if (kind_q == KIND_ALLOC_AT) begin
            if (mem_rd_data[want_bit]) begin
              out_status_next = ST_IN_USE;
            end else begin
              mem_wr_en         = 1'b1;
              mem_wr_addr       = want_word;
              mem_wr_data       = mem_rd_data | (WORD_BITS'(1) << want_bit);
              out_frame_next    = want_q;
              out_present_next  = 1'b1;
              out_writable_next = wr_q;
              out_user_next     = !kern_q;
            end
          end else begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cur_word;
            mem_wr_data = mem_rd_data & ~(WORD_BITS'(1) << cur_bit);
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      chk_valid <= chk_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr          <= ptr_next;
    chk_addr     <= chk_addr_next;
    out_status   <= out_status_next;
    out_frame    <= out_frame_next;
    out_present  <= out_present_next;
    out_writable <= out_writable_next;
    out_user     <= out_user_next;
    if (accept) begin
      kind_q <= kind_t'(req.kind);
      cur_q  <= req.current_frame;
      want_q <= req.wanted_frame;
      kern_q <= req.kernel_page;
      wr_q   <= req.rw_page;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.frame_index = out_frame;
  assign rsp.present     = out_present;
  assign rsp.writable    = out_writable;
  assign rsp.user_mode   = out_user;

`ifndef NO_ASSERTIONS
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_START)
    else $error("accepted word did not start processing");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> (state != S_IDLE && state != S_START))
    else $error("bitmap written outside clear, scan or modify");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && chk_valid) |-> chk_addr <= last_word)
    else $error("scan checked a word past the managed range");

  a_present_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.present) |-> rsp.status == ST_OK)
    else $error("present flag with a failing status");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rsp.ready) |=> out_valid && $stable(out_frame) && $stable(out_status))
    else $error("pending result changed while stalled");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/fba_bitmap_ram.sv -----
// fba_bitmap_ram: used-bit bitmap storage, one write and one read port
// read data registered; no dependencies
`default_nettype none

module fba_bitmap_ram #(
  parameter int WORD_BITS = 32,
  parameter int NUM_WORDS = 128,
  parameter int AW        = 7
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [WORD_BITS-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- dv/frame_bitmap_allocator_checker.sv -----
// frame_bitmap_allocator_checker: watches the request, result and config ports of the
// frame allocator, keeps its own copy of the used-bit map and compares every result word
// depends on fba_pkg and the fba_req_if / fba_rsp_if channel interfaces
`default_nettype none

module frame_bitmap_allocator_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  fba_req_if                                  req,
  fba_rsp_if                                  rsp,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [fba_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [fba_pkg::APB_DATA_W-1:0] pwdata,
  input  wire logic                           pready,
  output int                                  outstanding,
  output int                                  fail_count
);
  import fba_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] FCNT_ADDR = CFG_ADDR_W'(4 * REG_FRAME_COUNT);

  typedef struct packed {
    status_t            status;
    logic [FRAME_W-1:0] frame_index;
    logic               present;
    logic               writable;
    logic               user_mode;
  } grant_t;

  logic [MAX_FRAMES_DEF-1:0] frame_used;
  logic [FCNT_W-1:0]         managed_count;
  grant_t                    grants_due[$];

  task automatic grant_for_request(input kind_t k, input logic [FRAME_W-1:0] cur,
                                   input logic [FRAME_W-1:0] want, input logic kern,
                                   input logic wr, output grant_t g);
    int unsigned lim;
    int unsigned f;
    bit          found;
    lim = (32'(managed_count) > 32'(MAX_FRAMES_DEF)) ? 32'(MAX_FRAMES_DEF) :
          32'(managed_count);
    g.status      = ST_OK;
    g.frame_index = cur;
    g.present     = 1'b0;
    g.writable    = 1'b0;
    g.user_mode   = 1'b0;
    found         = 1'b0;
    f             = 0;
    case (k)
      KIND_ALLOC_FIRST, KIND_ALLOC_AT: begin
        if (cur != '0) begin
          g.status = ST_ALREADY;
        end else begin
          g.frame_index = '0;
          if (k == KIND_ALLOC_FIRST) begin
            while (f < lim && frame_used[f]) f++;
            if (f < lim) found = 1'b1;
            else g.status = ST_NO_FREE;
          end else begin
            f = 32'(want);
            if (f >= lim) g.status = ST_NO_FREE;
            else if (frame_used[f]) g.status = ST_IN_USE;
            else found = 1'b1;
          end
          if (found) begin
            frame_used[f] = 1'b1;
            g.frame_index = f[FRAME_W-1:0];
            g.present     = 1'b1;
            g.writable    = wr;
            g.user_mode   = ~kern;
          end
        end
      end
      KIND_FREE: begin
        g.frame_index = '0;
        if (cur == '0) g.status = ST_NOTHING;
        else frame_used[cur] = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s expected %0d got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    grant_t due;
    grant_t g;
    if (rst) begin
      frame_used    = '0;
      managed_count = FCNT_RESET;
      fail_count    = 0;
      grants_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (grants_due.size() == 0) begin
          $error("result word with nothing expected");
          fail_count++;
        end else begin
          due = grants_due.pop_front();
          check_field("status", 32'(due.status), 32'(rsp.status));
          check_field("frame_index", 32'(due.frame_index), 32'(rsp.frame_index));
          check_field("present", 32'(due.present), 32'(rsp.present));
          check_field("writable", 32'(due.writable), 32'(rsp.writable));
          check_field("user_mode", 32'(due.user_mode), 32'(rsp.user_mode));
        end
      end
      if (req.valid && req.ready) begin
        grant_for_request(kind_t'(req.kind), req.current_frame, req.wanted_frame,
                          req.kernel_page, req.rw_page, g);
        grants_due.push_back(g);
      end
      if (psel && penable && pwrite && pready && paddr == FCNT_ADDR)
        managed_count = pwdata[FCNT_W-1:0];
    end
    outstanding <= grants_due.size();
  end

endmodule

`default_nettype wire

// ----- dv/frame_bitmap_allocator_tb.sv -----
// frame_bitmap_allocator_tb: drives request words and frame count writes into the
// allocator with random gaps and result stalls; verdict from the checker's fail count
// depends on fba_pkg, the channel interfaces, the block and frame_bitmap_allocator_checker
`default_nettype none

module frame_bitmap_allocator_tb;
  import fba_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] FCNT_ADDR = CFG_ADDR_W'(4 * REG_FRAME_COUNT);
  localparam int PHASE_WORDS = 78;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  wire  [APB_DATA_W-1:0] prdata;
  wire                   pready;
  int                    outstanding;
  int                    fail_count;
  int unsigned           frame_limit;
  bit                    calm;

  fba_req_if req_ch ();
  fba_rsp_if rsp_ch ();

  frame_bitmap_allocator dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  frame_bitmap_allocator_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [FRAME_W-1:0] pick_frame();
    int unsigned r;
    int unsigned hi;
    r  = $urandom_range(0, 99);
    hi = (frame_limit > 1) ? frame_limit - 1 : 0;
    if (r < 70) return FRAME_W'($urandom_range(0, hi));
    if (r < 85) return FRAME_W'($urandom);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return FRAME_W'(hi);
      2:       return FRAME_W'(frame_limit);
      default: return '1;
    endcase
  endfunction

  task automatic send_word(input kind_t k, input logic [FRAME_W-1:0] cur,
                           input logic [FRAME_W-1:0] want, input logic kern,
                           input logic wr);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.kind          <= k;
    req_ch.current_frame <= cur;
    req_ch.wanted_frame  <= want;
    req_ch.kernel_page   <= kern;
    req_ch.rw_page       <= wr;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic random_word();
    int unsigned r;
    kind_t       k;
    logic [FRAME_W-1:0] cur;
    r = $urandom_range(0, 99);
    if (r < 40) k = KIND_ALLOC_FIRST;
    else if (r < 65) k = KIND_ALLOC_AT;
    else if (r < 95) k = KIND_FREE;
    else k = KIND_RSVD;
    if (k == KIND_FREE || $urandom_range(0, 99) < 15) cur = pick_frame();
    else cur = '0;
    send_word(k, cur, pick_frame(), 1'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame_count(input int unsigned count);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= FCNT_ADDR;
    pwdata  <= APB_DATA_W'(count);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    frame_limit = (count > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : count;
    @(posedge clk);
  endtask

  initial begin
    int unsigned hold;
    rsp_ch.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        rsp_ch.ready <= 1'b1;
        hold = $urandom_range(0, 6);
      end else begin
        rsp_ch.ready <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  initial begin
    int unsigned plan[9];
    plan = '{4096, 40, 1, 33, 8191, 0, 100, 0, 64};
    plan[7] = $urandom_range(2, 4096);
    calm                 = 1'b0;
    frame_limit          = MAX_FRAMES_DEF;
    rst                  <= 1'b1;
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_ch.valid         <= 1'b0;
    req_ch.kind          <= KIND_ALLOC_FIRST;
    req_ch.current_frame <= '0;
    req_ch.wanted_frame  <= '0;
    req_ch.kernel_page   <= 1'b0;
    req_ch.rw_page       <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: frame 0 handed out, top frame, refusals, free, reserved kind
    send_word(KIND_ALLOC_FIRST, '0, '0, 1'b0, 1'b0);
    send_word(KIND_ALLOC_FIRST, '0, '1, 1'b1, 1'b1);
    send_word(KIND_ALLOC_AT, '0, '1, 1'b0, 1'b1);
    send_word(KIND_ALLOC_AT, '0, '1, 1'b1, 1'b0);
    send_word(KIND_ALLOC_AT, '0, '0, 1'b0, 1'b0);
    send_word(KIND_ALLOC_FIRST, '1, '0, 1'b1, 1'b1);
    send_word(KIND_ALLOC_AT, 12'd5, 12'd7, 1'b0, 1'b1);
    send_word(KIND_FREE, '0, '1, 1'b1, 1'b1);
    send_word(KIND_FREE, 12'd1, '0, 1'b0, 1'b0);
    send_word(KIND_ALLOC_FIRST, '0, '0, 1'b1, 1'b0);
    send_word(KIND_FREE, '1, '0, 1'b0, 1'b0);
    send_word(KIND_FREE, '1, '1, 1'b1, 1'b1);
    send_word(KIND_RSVD, 12'hABC, 12'h543, 1'b1, 1'b1);
    send_word(KIND_RSVD, '0, '0, 1'b0, 1'b0);
    set_frame_count(1);
    send_word(KIND_ALLOC_FIRST, '0, '0, 1'b0, 1'b1);
    send_word(KIND_ALLOC_AT, '0, 12'd1, 1'b0, 1'b1);
    set_frame_count(0);
    send_word(KIND_ALLOC_FIRST, '0, '0, 1'b1, 1'b1);
    send_word(KIND_ALLOC_AT, '0, '0, 1'b1, 1'b1);
    set_frame_count(3);
    send_word(KIND_ALLOC_FIRST, '0, '0, 1'b0, 1'b1);
    send_word(KIND_ALLOC_FIRST, '0, '0, 1'b0, 1'b1);
    set_frame_count(8191);
    send_word(KIND_ALLOC_AT, '0, '1, 1'b0, 1'b0);
    send_word(KIND_ALLOC_FIRST, '0, '0, 1'b1, 1'b0);

    for (int p = 0; p < 9; p++) begin
      calm = 1'b0;
      set_frame_count(plan[p]);
      calm = (p % 3 == 1);
      for (int i = 0; i < PHASE_WORDS; i++) random_word();
    end

    calm = 1'b0;
    drain();
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 900000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
